@@ hw/rtl/stsw_pkg.sv @@
// Package for the signed trilinear splat weight block.
// Holds the field widths, fixed-point constants and the payload tag type.
// No dependencies.
`default_nettype none

package stsw_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int NUM_AXES   = 3;

	localparam int SITE_W   = COORD_BITS + 1;
	localparam int OFF_W    = FRAC_BITS + 2;
	localparam int POL_W    = 2;
	localparam int WGT_W    = FRAC_BITS + 1;
	localparam int PROD_W   = 2 * WGT_W;
	localparam int TRIPLE_W = 3 * WGT_W;
	localparam int SHARE_W  = FRAC_BITS + 2;
	localparam int SUM_W    = FRAC_BITS + 4;
	localparam int ERR_W    = 5;

	localparam int IN_BITS     = NUM_AXES * COORD_BITS + NUM_AXES * OFF_W + POL_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = NUM_AXES * SITE_W + SHARE_W + ERR_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [WGT_W-1:0]        ONE_WGT    = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [OFF_W-1:0] ONE_OFF    = {2'b01, {FRAC_BITS{1'b0}}};
	localparam logic [TRIPLE_W-1:0]     ROUND_HALF = TRIPLE_W'(1) << (2 * FRAC_BITS - 1);
	localparam logic signed [SUM_W:0]   ONE_SUM    = {5'b00001, {FRAC_BITS{1'b0}}};
	localparam logic signed [SITE_W-1:0] SITE_PLUS  = SITE_W'(1);
	localparam logic signed [SITE_W-1:0] SITE_MINUS = {SITE_W{1'b1}};

	localparam logic signed [POL_W-1:0] POL_POS = 2'sb01;
	localparam logic signed [POL_W-1:0] POL_NEG = 2'sb11;

	// Per-result information that travels alongside the weight arithmetic.
	typedef struct packed {
		logic                     ok;
		logic                     last;
		logic                     neg;
		logic signed [SITE_W-1:0] sx;
		logic signed [SITE_W-1:0] sy;
		logic signed [SITE_W-1:0] sz;
	} tag_t;

endpackage

`default_nettype wire

@@ hw/rtl/signed_trilinear_splat_weights.sv @@
// An input transfer is registered in stage 1, and its first result reaches the output register through stages 2 to 6.
// Each input item yields 1, 2, 4 or 8 deposit sites (two sites on each
// axis with a fractional offset); the combination sequencer issues one site per cycle while stage 2 can take it.
// Results stream through a six-stage pipeline that stalls stage by stage without loss.
// Reset clears all valid bits, the site counter and the running weight sum.
// Depends on stsw_pkg.
`default_nettype none

module signed_trilinear_splat_weights
	import stsw_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// anchor_x, anchor_y, anchor_z, offset_x, offset_y, offset_z, charge_sign, zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// site_x, site_y, site_z, share, sum_error, zero pad
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// ok
	output logic [0:0]                  m_axis_tuser,
	output logic                        m_axis_tlast
);

	// Input unpacking and per-axis decode
	logic signed [COORD_BITS-1:0] anc [NUM_AXES];
	logic signed [OFF_W-1:0]      off [NUM_AXES];
	logic signed [POL_W-1:0]      pol;
	logic signed [SITE_W-1:0]     dec_site0 [NUM_AXES];
	logic signed [SITE_W-1:0]     dec_site1 [NUM_AXES];
	logic [WGT_W-1:0]             dec_w0 [NUM_AXES];
	logic [WGT_W-1:0]             dec_w1 [NUM_AXES];
	logic [NUM_AXES-1:0]          dec_two;
	logic                         dec_ok;

	always_comb begin
		logic signed [OFF_W-1:0]  off_abs;
		logic [WGT_W-1:0]         f;
		logic signed [SITE_W-1:0] anc_ext;
		logic signed [SITE_W-1:0] nbr;
		pol = s_axis_tdata[NUM_AXES*COORD_BITS + NUM_AXES*OFF_W +: POL_W];
		dec_ok = (pol == POL_POS) || (pol == POL_NEG);
		for (int a = 0; a < NUM_AXES; a++) begin
			anc[a] = s_axis_tdata[a*COORD_BITS +: COORD_BITS];
			off[a] = s_axis_tdata[NUM_AXES*COORD_BITS + a*OFF_W +: OFF_W];
			if ((off[a] > ONE_OFF) || (off[a] < -ONE_OFF)) begin
				dec_ok = 1'b0;
			end
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			off_abs = off[a][OFF_W-1] ? -off[a] : off[a];
			f       = off_abs[WGT_W-1:0];
			anc_ext = SITE_W'(anc[a]);
			nbr     = anc_ext + (off[a][OFF_W-1] ? SITE_MINUS : SITE_PLUS);
			dec_site0[a] = anc_ext;
			dec_site1[a] = nbr;
			dec_w0[a]    = ONE_WGT;
			dec_w1[a]    = f;
			dec_two[a]   = 1'b0;
			if (f == ONE_WGT) begin
				dec_site0[a] = nbr;
			end else if (f != '0) begin
				dec_w0[a]  = ONE_WGT - f;
				dec_two[a] = dec_ok;
			end
		end
	end

	// Stage 1: decoded item held while its sites are issued
	logic                     v_s1;
	logic                     ok_s1;
	logic                     neg_s1;
	logic [NUM_AXES-1:0]      two_s1;
	logic signed [SITE_W-1:0] site0_s1 [NUM_AXES];
	logic signed [SITE_W-1:0] site1_s1 [NUM_AXES];
	logic [WGT_W-1:0]         w0_s1 [NUM_AXES];
	logic [WGT_W-1:0]         w1_s1 [NUM_AXES];
	logic [NUM_AXES-1:0]      idx_q;

	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic v_s2, v_s3, v_s4, v_s5, v_s6;

	logic                     accept;
	logic                     issue;
	logic                     last_combo;
	logic [NUM_AXES-1:0]      idx_nxt;
	logic signed [SITE_W-1:0] site_sel [NUM_AXES];
	logic [WGT_W-1:0]         w_sel [NUM_AXES];

	// Bit 0 of the index walks x (outermost), bit 2 walks z (innermost).
	assign last_combo    = (idx_q == two_s1);
	assign issue         = v_s1 && rdy_s2;
	assign s_axis_tready = !v_s1 || (rdy_s2 && last_combo);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		idx_nxt = idx_q;
		if (idx_q[2] != two_s1[2]) begin
			idx_nxt[2] = 1'b1;
		end else begin
			idx_nxt[2] = 1'b0;
			if (idx_q[1] != two_s1[1]) begin
				idx_nxt[1] = 1'b1;
			end else begin
				idx_nxt[1] = 1'b0;
				idx_nxt[0] = 1'b1;
			end
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			site_sel[a] = idx_q[a] ? site1_s1[a] : site0_s1[a];
			w_sel[a]    = idx_q[a] ? w1_s1[a] : w0_s1[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (accept) begin
				v_s1  <= 1'b1;
				idx_q <= '0;
			end else if (issue) begin
				if (last_combo) begin
					v_s1  <= 1'b0;
					idx_q <= '0;
				end else begin
					idx_q <= idx_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1  <= dec_ok;
			neg_s1 <= pol[POL_W-1];
			two_s1 <= dec_two;
			for (int a = 0; a < NUM_AXES; a++) begin
				site0_s1[a] <= dec_site0[a];
				site1_s1[a] <= dec_site1[a];
				w0_s1[a]    <= dec_w0[a];
				w1_s1[a]    <= dec_w1[a];
			end
		end
	end

	// Stages 2 to 6: one deposit site per transfer
	tag_t                tag_s2, tag_s3, tag_s4, tag_s5;
	logic [WGT_W-1:0]    wa_s2, wb_s2, wc_s2, wc_s3;
	logic [PROD_W-1:0]   p_s3;
	logic [TRIPLE_W-1:0] q_s4;
	logic [WGT_W-1:0]    mag_s5;

	assign rdy_s6 = !v_s6 || m_axis_tready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	logic [TRIPLE_W-1:0] rounded;
	assign rounded = q_s4 + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (issue) begin
			tag_s2.ok   <= ok_s1;
			tag_s2.last <= last_combo;
			tag_s2.neg  <= neg_s1;
			tag_s2.sx   <= site_sel[0];
			tag_s2.sy   <= site_sel[1];
			tag_s2.sz   <= site_sel[2];
			wa_s2       <= w_sel[0];
			wb_s2       <= w_sel[1];
			wc_s2       <= w_sel[2];
		end
		if (rdy_s3 && v_s2) begin
			tag_s3 <= tag_s2;
			p_s3   <= PROD_W'(wa_s2) * PROD_W'(wb_s2);
			wc_s3  <= wc_s2;
		end
		if (rdy_s4 && v_s3) begin
			tag_s4 <= tag_s3;
			q_s4   <= TRIPLE_W'(p_s3) * TRIPLE_W'(wc_s3);
		end
		if (rdy_s5 && v_s4) begin
			tag_s5 <= tag_s4;
			mag_s5 <= rounded[2*FRAC_BITS +: WGT_W];
		end
	end

	// Output stage: sign the share and close the partition residual on the last site.
	logic [SUM_W-1:0]           sum_q;
	logic [SUM_W-1:0]           sum_nxt;
	logic signed [SUM_W:0]      diff;
	logic signed [SUM_W:0]      err_full;
	logic signed [SHARE_W-1:0]  mag_ext;
	logic signed [SHARE_W-1:0]  share_val;

	logic                       ok_s6;
	logic                       last_s6;
	logic signed [SITE_W-1:0]   sx_s6, sy_s6, sz_s6;
	logic signed [SHARE_W-1:0]  share_s6;
	logic signed [ERR_W-1:0]    err_s6;

	always_comb begin
		sum_nxt   = sum_q + SUM_W'(mag_s5);
		diff      = $signed({1'b0, sum_nxt}) - ONE_SUM;
		err_full  = tag_s5.neg ? -diff : diff;
		mag_ext   = SHARE_W'(mag_s5);
		share_val = tag_s5.neg ? -mag_ext : mag_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (rdy_s6 && v_s5) begin
			sum_q <= tag_s5.last ? '0 : sum_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			ok_s6    <= tag_s5.ok;
			last_s6  <= tag_s5.last;
			sx_s6    <= tag_s5.ok ? tag_s5.sx : '0;
			sy_s6    <= tag_s5.ok ? tag_s5.sy : '0;
			sz_s6    <= tag_s5.ok ? tag_s5.sz : '0;
			share_s6 <= tag_s5.ok ? share_val : '0;
			err_s6   <= (tag_s5.ok && tag_s5.last) ? err_full[ERR_W-1:0] : '0;
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tlast  = last_s6;
	assign m_axis_tuser  = ok_s6;
	assign m_axis_tdata  = OUT_TDATA_W'({err_s6, share_s6, sz_s6, sy_s6, sx_s6});

endmodule

`default_nettype wire

@@ tb/sv/tb_signed_trilinear_splat_weights.sv @@
// Self-checking testbench for signed_trilinear_splat_weights: drives anchor, offset and polarity
// transfers, predicts every deposit site, share and residual, and scoreboards the output stream.
// Depends on stsw_pkg and the signed_trilinear_splat_weights RTL.

module tb_signed_trilinear_splat_weights;
	import stsw_pkg::*;

	localparam int UNIT       = 1 << FRAC_BITS;
	localparam int OFF_LSB    = NUM_AXES * COORD_BITS;
	localparam int POL_LSB    = OFF_LSB + NUM_AXES * OFF_W;
	localparam int SHARE_LSB  = NUM_AXES * SITE_W;
	localparam int ERR_LSB    = SHARE_LSB + SHARE_W;
	localparam int CYCLE_CAP  = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 20;

	// Polarity codes that the block must reject.
	localparam logic [POL_W-1:0] POL_ZERO = 2'b00;
	localparam logic [POL_W-1:0] POL_LOW  = 2'b10;

	typedef struct packed {
		logic                      ok;
		logic signed [SITE_W-1:0]  sx;
		logic signed [SITE_W-1:0]  sy;
		logic signed [SITE_W-1:0]  sz;
		logic signed [SHARE_W-1:0] share;
		logic signed [ERR_W-1:0]   err;
		logic                      last;
	} deposit_t;

	class deposit_scoreboard;
		deposit_t pending_sites[$];
		int n_inputs;
		int n_invalid;
		int n_results;
		int n_errors;

		function int pending();
			return pending_sites.size();
		endfunction

		// Works out the deposit sites and signed shares that one input transfer produces.
		function void note_input(logic [IN_TDATA_W-1:0] d);
			logic signed [COORD_BITS-1:0] anc;
			logic signed [OFF_W-1:0]      off;
			logic signed [POL_W-1:0]      pol;
			logic signed [SITE_W-1:0]     site [NUM_AXES][2];
			longint unsigned              wgt [NUM_AXES][2];
			longint unsigned              mag;
			longint unsigned              wsum;
			int                           cnt [NUM_AXES];
			int                           offs [NUM_AXES];
			int                           ancs [NUM_AXES];
			int                           a, ix, iy, iz, dir, resid;
			bit                           valid, neg;
			deposit_t                     r;
			n_inputs++;
			pol = d[POL_LSB +: POL_W];
			valid = (pol == POL_POS) || (pol == POL_NEG);
			neg = (pol == POL_NEG);
			for (a = 0; a < NUM_AXES; a++) begin
				anc = d[a*COORD_BITS +: COORD_BITS];
				off = d[OFF_LSB + a*OFF_W +: OFF_W];
				ancs[a] = anc;
				offs[a] = off;
				if (offs[a] < -UNIT || offs[a] > UNIT)
					valid = 1'b0;
			end
			if (!valid) begin
				n_invalid++;
				r = '0;
				r.last = 1'b1;
				pending_sites.push_back(r);
				return;
			end
			for (a = 0; a < NUM_AXES; a++) begin
				dir = (offs[a] < 0) ? -1 : 1;
				if (offs[a] == 0) begin
					site[a][0] = SITE_W'(ancs[a]);
					wgt[a][0] = UNIT;
					cnt[a] = 1;
				end else if (offs[a] == UNIT || offs[a] == -UNIT) begin
					site[a][0] = SITE_W'(ancs[a] + dir);
					wgt[a][0] = UNIT;
					cnt[a] = 1;
				end else begin
					site[a][0] = SITE_W'(ancs[a]);
					site[a][1] = SITE_W'(ancs[a] + dir);
					wgt[a][0] = UNIT - offs[a] * dir;
					wgt[a][1] = offs[a] * dir;
					cnt[a] = 2;
				end
			end
			wsum = 0;
			for (ix = 0; ix < cnt[0]; ix++)
				for (iy = 0; iy < cnt[1]; iy++)
					for (iz = 0; iz < cnt[2]; iz++) begin
						// The exact product has 48 fraction bits; round half up to 16.
						mag = (wgt[0][ix] * wgt[1][iy] * wgt[2][iz] +
							(64'd1 << (2*FRAC_BITS - 1))) >> (2*FRAC_BITS);
						wsum = (wsum + mag) & ((64'd1 << SUM_W) - 1);
						r.ok = 1'b1;
						r.sx = site[0][ix];
						r.sy = site[1][iy];
						r.sz = site[2][iz];
						r.share = neg ? -SHARE_W'(mag) : SHARE_W'(mag);
						r.last = (ix == cnt[0]-1) && (iy == cnt[1]-1) && (iz == cnt[2]-1);
						resid = int'(wsum) - UNIT;
						r.err = r.last ? ERR_W'(neg ? -resid : resid) : '0;
						pending_sites.push_back(r);
					end
		endfunction

		function void mismatch(string field, longint want, longint got);
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			n_errors++;
		endfunction

		function void check_result(deposit_t got);
			deposit_t want;
			n_results++;
			if (pending_sites.size() == 0) begin
				$error("result transfer with nothing expected: site (%0d, %0d, %0d), share %0d",
					got.sx, got.sy, got.sz, got.share);
				n_errors++;
				return;
			end
			want = pending_sites.pop_front();
			if (got.ok !== want.ok)
				mismatch("ok", want.ok, got.ok);
			if (got.sx !== want.sx)
				mismatch("site_x", want.sx, got.sx);
			if (got.sy !== want.sy)
				mismatch("site_y", want.sy, got.sy);
			if (got.sz !== want.sz)
				mismatch("site_z", want.sz, got.sz);
			if (got.share !== want.share)
				mismatch("share", want.share, got.share);
			if (got.err !== want.err)
				mismatch("sum_error", want.err, got.err);
			if (got.last !== want.last)
				mismatch("last", want.last, got.last);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;
	logic                   m_axis_tlast;

	deposit_scoreboard sb = new();
	bit  hold_req;
	bit  tx_gapless;
	bit  rx_gapless;
	int  cycles;

	signed_trilinear_splat_weights i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_input(s_axis_tdata);
	end

	always @(posedge clk) begin
		deposit_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.ok    = m_axis_tuser[0];
			got.sx    = m_axis_tdata[0 +: SITE_W];
			got.sy    = m_axis_tdata[SITE_W +: SITE_W];
			got.sz    = m_axis_tdata[2*SITE_W +: SITE_W];
			got.share = m_axis_tdata[SHARE_LSB +: SHARE_W];
			got.err   = m_axis_tdata[ERR_LSB +: ERR_W];
			got.last  = m_axis_tlast;
			sb.check_result(got);
		end
	end

	// Output side: a fresh random stall before every result, none when gapless, or one long hold-off when asked.
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall = rx_gapless ? 0 : $urandom_range(0, 12);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	function automatic int draw_gap();
		return tx_gapless ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_item(int ax, int ay, int az, int ox, int oy,
		int oz, logic [POL_W-1:0] pol);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[0 +: COORD_BITS]                 = COORD_BITS'(ax);
		d[COORD_BITS +: COORD_BITS]        = COORD_BITS'(ay);
		d[2*COORD_BITS +: COORD_BITS]      = COORD_BITS'(az);
		d[OFF_LSB +: OFF_W]                = OFF_W'(ox);
		d[OFF_LSB + OFF_W +: OFF_W]        = OFF_W'(oy);
		d[OFF_LSB + 2*OFF_W +: OFF_W]      = OFF_W'(oz);
		d[POL_LSB +: POL_W]                = pol;
		return d;
	endfunction

	function automatic int rand_offset();
		int corner [8] = '{0, UNIT, -UNIT, 1, -1, UNIT - 1, -(UNIT - 1), UNIT / 2};
		if ($urandom_range(0, 4) == 0)
			return corner[$urandom_range(0, 7)];
		return int'($urandom_range(0, 2*UNIT)) - UNIT;
	endfunction

	function automatic int rand_anchor();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 32767 : -32768;
		return $urandom_range(0, 65535);
	endfunction

	// Mostly well-formed transfers, with a few bad polarities and out-of-range offsets.
	function automatic logic [IN_TDATA_W-1:0] random_item();
		int               off [NUM_AXES];
		logic [POL_W-1:0] pol;
		int               kind, a;
		for (a = 0; a < NUM_AXES; a++)
			off[a] = rand_offset();
		pol = $urandom_range(0, 1) ? POL_POS : POL_NEG;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			pol = $urandom_range(0, 1) ? POL_ZERO : POL_LOW;
		end else if (kind < 12) begin
			a = $urandom_range(0, NUM_AXES - 1);
			off[a] = $urandom_range(0, 1) ? int'($urandom_range(UNIT + 1, 2*UNIT - 1))
				: -int'($urandom_range(UNIT + 1, 2*UNIT));
		end
		return pack_item(rand_anchor(), rand_anchor(), rand_anchor(), off[0], off[1], off[2], pol);
	endfunction

	task automatic send_item(input logic [IN_TDATA_W-1:0] d, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_random(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_item(random_item(), draw_gap());
	endtask

	// The last transfer has just been taken, so the input goes idle while the output drains.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: single sites, full eight-site splats, rounding and rejects.
		send_item(pack_item(0, 0, 0, 0, 0, 0, POL_POS), draw_gap());
		send_item(pack_item(32767, 32767, 32767, UNIT, UNIT, UNIT, POL_POS), draw_gap());
		send_item(pack_item(-32768, -32768, -32768, -UNIT, -UNIT, -UNIT, POL_NEG), draw_gap());
		send_item(pack_item(5, -7, 9, UNIT/2, UNIT/2, UNIT/2, POL_POS), draw_gap());
		send_item(pack_item(-1, 1, 100, -UNIT/2, -1, UNIT - 1, POL_NEG), draw_gap());
		// The product of weights 2^-16, 0.5 and 1 sits exactly on a rounding midpoint.
		send_item(pack_item(10, 20, 30, 1, UNIT/2, 0, POL_POS), draw_gap());
		send_item(pack_item(3, 3, 3, 1, 1, 1, POL_NEG), draw_gap());
		send_item(pack_item(32767, -32768, 0, -(UNIT - 1), UNIT - 1, -1, POL_POS), draw_gap());
		send_item(pack_item(1, 2, 3, UNIT + 1, 0, 0, POL_POS), draw_gap());
		send_item(pack_item(1, 2, 3, 0, -(UNIT + 1), 0, POL_NEG), draw_gap());
		send_item(pack_item(1, 2, 3, 0, 0, 2*UNIT - 1, POL_POS), draw_gap());
		send_item(pack_item(1, 2, 3, -2*UNIT, 0, 0, POL_NEG), draw_gap());
		send_item(pack_item(-5, 6, -7, UNIT/4, UNIT/4, UNIT/4, POL_ZERO), draw_gap());
		send_item(pack_item(-5, 6, -7, UNIT/4, UNIT/4, UNIT/4, POL_LOW), draw_gap());
		send_item(pack_item(32767, -32768, -1, 40000, -40000, 12345, POL_POS), draw_gap());
		send_item(pack_item(0, 0, 0, 21845, 43690, 10923, POL_NEG), draw_gap());
		send_item(pack_item(-100, 100, -100, UNIT, -UNIT/2, 0, POL_NEG), draw_gap());
		send_item(pack_item(7, 7, 7, 0, 0, -(UNIT - 1), POL_POS), draw_gap());

		send_random(60);

		// Long output hold-off while the input keeps streaming, so the pipeline backs up.
		wait_drained();
		hold_req = 1'b1;
		tx_gapless = 1'b1;
		send_random(30);
		tx_gapless = 1'b0;

		// Input pauses until the output has caught up, then both sides run flat out.
		wait_drained();
		tx_gapless = 1'b1;
		rx_gapless = 1'b1;
		send_random(25);
		tx_gapless = 1'b0;
		rx_gapless = 1'b0;

		send_random(27);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.n_errors++;
		end
		$display("Run covered %0d input transfers (%0d rejected) and %0d result transfers,",
			sb.n_inputs, sb.n_invalid, sb.n_results);
		$display("including a %0d-cycle output hold-off and gapless streaming; %0d mismatches.",
			HOLD_CYCLES, sb.n_errors);
		if (sb.n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
